### rtl/core/sfh_pkg.sv
// ----------------------------------------------------------------------------
// Stationary foreground history package
// Shared constants, register indexes and types of the history unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfh_pkg;

    // Widths fixed by the interface.
    localparam int ADDR_W    = 17;
    localparam int MASK_W    = 8;
    localparam int HIST_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Largest number of pixels the address field can reach.
    localparam int ADDR_SPAN = 1 << ADDR_W;

    localparam int PIXEL_COUNT_DEFAULT = 131072;

    // Mask codes and the counter ceiling.
    localparam logic [MASK_W-1:0] MASK_FOREGROUND = 8'd255;
    localparam logic [MASK_W-1:0] MASK_BACKGROUND = 8'd0;
    localparam logic [HIST_W-1:0] COUNTER_MAX     = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] INCREMENT_RESET = 8'd1;
    localparam logic [CFG_W-1:0] DECREMENT_RESET = 8'd15;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 8'd40;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              stationary;
        logic [HIST_W-1:0] history;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/stationary_foreground_history_unit.sv
// ----------------------------------------------------------------------------
// Stationary foreground history unit
// Per-pixel history counters held in one synchronous memory, updated by a
// read-modify-write on every in-range mask beat, with a stationary flag per result.
// ----------------------------------------------------------------------------
// The unit accepts one input beat per clock cycle while o_ready is high and
// returns one result beat per input beat, in order. A beat enters, reads its
// pixel's counter from the history memory at the accept edge, and at the
// following edge the updated counter is written back and the result enters a
// four-entry output queue, from which the consumer can take it. The single
// read-modify-write path of the memory sets the rate of one beat per cycle: a
// beat that reads a pixel the previous beat is writing in the same cycle takes
// the new value from a forwarding register. The output queue lets the unit
// keep taking beats while finished results wait for the consumer. After reset
// the unit clears every entry of the memory, one entry per cycle; o_ready stays
// low during that pass, while configuration writes are taken at any time.
// Addresses at or above PIXEL_COUNT leave the memory untouched and return a
// zero history with the stationary flag low. Configuration is expected to
// change only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stationary_foreground_history_unit
    import sfh_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,

    // Input channel.
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [ADDR_W-1:0]    i_pixel_address,
    input  wire logic [MASK_W-1:0]    i_mask_value,

    // Output channel.
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_stationary,
    output logic [HIST_W-1:0]         o_history_value
);

    // Only addresses the input field can reach need storage.
    localparam int DEPTH = (PIXEL_COUNT < ADDR_SPAN) ? PIXEL_COUNT : ADDR_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [31:0]   PIXEL_LIMIT = 32'(PIXEL_COUNT);

    typedef struct packed {
        logic              valid;
        logic              in_range;
        logic [MASK_W-1:0] mask;
        logic [AW-1:0]     idx;
    } t_stage;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_increment;
    logic [CFG_W-1:0] r_decrement;
    logic [CFG_W-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_increment <= INCREMENT_RESET;
            r_decrement <= DECREMENT_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INCREMENT: r_increment <= i_cfg_data;
                CFG_DECREMENT: r_decrement <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: begin
                    // An unused index is ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset.
    // ------------------------------------------------------------------
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_clr_idx;
    logic [AW-1:0] n_clr_idx;
    logic          w_clr_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        w_clr_we  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_clr_we  = 1'b1;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Input acceptance and the read stage.
    // ------------------------------------------------------------------
    logic [QAW:0] r_count;
    t_stage       r_s1;
    logic         w_accept;
    logic         w_in_range;

    // A beat may enter only if every beat already in flight, plus this one,
    // is sure to find a queue slot even if the consumer stalls.
    assign o_ready  = (r_state == ST_RUN)
                   && ((r_count + (QAW+1)'(r_s1.valid)) < (QAW+1)'(QDEPTH));
    assign w_accept = i_valid && o_ready;

    assign w_in_range = (32'(i_pixel_address) < PIXEL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= w_accept;
        end
        if (w_accept) begin
            r_s1.in_range <= w_in_range;
            r_s1.mask     <= i_mask_value;
            r_s1.idx      <= i_pixel_address[AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // History memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [HIST_W-1:0] r_mem [DEPTH];
    logic [HIST_W-1:0] r_rdata;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_widx;
    logic [HIST_W-1:0] w_mem_wdata;
    logic [HIST_W-1:0] w_hist;
    logic              w_s1_write;

    assign w_s1_write  = r_s1.valid && r_s1.in_range;
    assign w_mem_we    = w_clr_we || w_s1_write;
    assign w_mem_widx  = w_clr_we ? r_clr_idx : r_s1.idx;
    assign w_mem_wdata = w_clr_we ? '0 : w_hist;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_range) begin
            r_rdata <= r_mem[i_pixel_address[AW-1:0]];
        end
        if (w_mem_we) begin
            r_mem[w_mem_widx] <= w_mem_wdata;
        end
    end

    // The write made at the same edge as this beat's read is not yet in the
    // read data, so it is forwarded from here.
    logic              r_wb_valid;
    logic [AW-1:0]     r_wb_idx;
    logic [HIST_W-1:0] r_wb_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= w_s1_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_write) begin
            r_wb_idx  <= r_s1.idx;
            r_wb_data <= w_hist;
        end
    end

    // ------------------------------------------------------------------
    // Update stage.
    // ------------------------------------------------------------------
    logic [HIST_W-1:0] w_cur;
    logic [HIST_W:0]   w_sum;
    t_result           w_result;

    assign w_cur = (r_wb_valid && (r_wb_idx == r_s1.idx)) ? r_wb_data : r_rdata;
    assign w_sum = {1'b0, w_cur} + {1'b0, r_increment};

    always_comb begin
        case (r_s1.mask)
            MASK_FOREGROUND: w_hist = w_sum[HIST_W] ? COUNTER_MAX : w_sum[HIST_W-1:0];
            MASK_BACKGROUND: w_hist = (w_cur > r_decrement) ? (w_cur - r_decrement) : '0;
            default:         w_hist = w_cur;
        endcase
    end

    always_comb begin
        if (r_s1.in_range) begin
            w_result.stationary = (w_hist >= r_threshold);
            w_result.history    = w_hist;
        end else begin
            w_result.stationary = 1'b0;
            w_result.history    = '0;
        end
    end

    // ------------------------------------------------------------------
    // Output queue.
    // ------------------------------------------------------------------
    t_result      r_queue [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic           w_push;
    logic           w_pop;

    assign w_push = r_s1.valid;
    assign w_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            r_count <= r_count + (QAW+1)'(w_push) - (QAW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wptr] <= w_result;
        end
    end

    assign o_valid         = (r_count != '0);
    assign o_stationary    = r_queue[r_rptr].stationary;
    assign o_history_value = r_queue[r_rptr].history;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Beats in flight never exceed the queue slots reserved for them.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + (QAW+1)'(r_s1.valid)) <= (QAW+1)'(QDEPTH))
        else $error("result queue can overflow");

    // Nothing is in flight while the memory is being cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!r_s1.valid && (r_count == '0) && !o_ready))
        else $error("beat in flight during clearing pass");

    // An out-of-range beat leaves nothing to forward.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && !r_s1.in_range) |=> !r_wb_valid)
        else $error("out-of-range beat wrote the history memory");

    // A clearing write never collides with an update write.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_clr_we && w_s1_write))
        else $error("clearing pass and update share the write port");

endmodule

`default_nettype wire
